FILE: hdl/ssld_pkg.sv
// Shared types, widths and constants of the swim stroke and length detector.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ssld_pkg;

   // Field and register widths.
   localparam int TIME_W     = 32;
   localparam int PC_W       = 16;
   localparam int ACCEL_W    = 13;
   localparam int MS_W       = 16;
   localparam int SPL_W      = 8;
   localparam int STROKES_W  = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_THRESHOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_PEAK_MS        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_AVG_GAP_MS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_AVG_GAP_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STROKES_PER_LENGTH = 3'd4;

   // Register values after reset.
   localparam logic [ACCEL_W-1:0] RST_PEAK_THRESHOLD     = 13'd1100;
   localparam logic [MS_W-1:0]    RST_MIN_PEAK_MS        = 16'd150;
   localparam logic [MS_W-1:0]    RST_MAX_AVG_GAP_MS     = 16'd2500;
   localparam logic [MS_W-1:0]    RST_INITIAL_AVG_GAP_MS = 16'd1000;
   localparam logic [SPL_W-1:0]   RST_STROKES_PER_LENGTH = 8'd12;

   // Algorithm constants.
   localparam int PCT_FULL      = 100;
   localparam int WIN_BASE      = 200;
   localparam int AVG_MIN_COUNT = 6;
   localparam logic [STROKES_W-1:0] STROKES_MAX = '1;

   // Divider sizing: the running average divides avg*(n-1)+gap by n,
   // the window percentage divides 100*(S-s) by S.
   localparam int APROD_W   = MS_W + PC_W;
   localparam int DIVD_W    = ((APROD_W > TIME_W) ? APROD_W : TIME_W) + 1;
   localparam int DVSR_W    = (PC_W > SPL_W) ? PC_W : SPL_W;
   localparam int STEP_W    = $clog2(DIVD_W + 1);
   localparam int PCT_NUM_W = $clog2(PCT_FULL * ((1 << SPL_W) - 1) + 1);
   localparam int PCT_W     = $clog2(PCT_FULL + 1);

   // Window: avg*(200 + 2*pct) / 100, the division done by a reciprocal
   // multiply that is exact for products below 2^30.
   localparam int FACT_W       = $clog2(WIN_BASE + 2 * PCT_FULL + 1);
   localparam int WPROD_W      = MS_W + FACT_W;
   localparam int RECIP_SHIFT  = 32;
   localparam longint unsigned RECIP_K =
      ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
   localparam int K_W          = $clog2(RECIP_K);
   localparam int SCALE_W      = WPROD_W + K_W;
   localparam int WIN_W        = SCALE_W - RECIP_SHIFT;
   localparam int WCMP_W       = (TIME_W > WIN_W) ? TIME_W : WIN_W;
   localparam int CMP_W        = PC_W + STROKES_W;

   typedef struct packed {
      logic [ACCEL_W-1:0] accel;
      logic [TIME_W-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic                 length_done;
      logic [STROKES_W-1:0] length_strokes;
      logic [TIME_W-1:0]    length_start_ms;
      logic [TIME_W-1:0]    length_end_ms;
      logic                 peak_counted;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic peak;
      logic peak_commit;
      logic avg_mul;
      logic avg_div;
      logic avg_commit;
      logic pct_div;
      logic pct_zero;
      logic pct_load;
      logic win_mul;
      logic win_scale;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic qualify;
      logic need_avg;
      logic pct_needed;
      logic div_busy;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/ssld_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by the datapath.
// Depends on ssld_pkg for its widths.
`default_nettype none

module ssld_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ssld_pkg::DIVD_W-1:0]   dividend,
   input  wire logic [ssld_pkg::DVSR_W-1:0]   divisor,
   input  wire logic [ssld_pkg::STEP_W-1:0]   steps,
   output logic                               busy,
   output logic      [ssld_pkg::DIVD_W-1:0]   quotient
);

   logic [ssld_pkg::DIVD_W-1:0] quot_ff, quot_in;
   logic [ssld_pkg::DVSR_W-1:0] rem_ff, rem_in;
   logic [ssld_pkg::DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [ssld_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic [ssld_pkg::DVSR_W:0]   shifted;
   logic [ssld_pkg::DVSR_W+1:0] trial;

   // The partial remainder takes the next dividend bit from the top of the
   // quotient register; quotient bits enter at the bottom.
   assign shifted = {rem_ff, quot_ff[ssld_pkg::DIVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvsr_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[ssld_pkg::DVSR_W+1]) begin
            rem_in  = trial[ssld_pkg::DVSR_W-1:0];
            quot_in = {quot_ff[ssld_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[ssld_pkg::DVSR_W-1:0];
            quot_in = {quot_ff[ssld_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ssld_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: hdl/ssld_dp.sv
// Datapath: configuration registers, detector state, multipliers, the shared
// divider and the result register. Depends on ssld_pkg and ssld_div.
`default_nettype none

module ssld_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ssld_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ssld_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire ssld_pkg::req_type                   req_data,
   input  wire ssld_pkg::ctrl_cmd_type              cmd,
   output ssld_pkg::dp_status_type                  status,
   output ssld_pkg::rsp_type                        rsp_data
);

   // Configuration.
   logic [ssld_pkg::ACCEL_W-1:0] thr_ff, thr_in;
   logic [ssld_pkg::MS_W-1:0]    min_ff, min_in;
   logic [ssld_pkg::MS_W-1:0]    max_ff, max_in;
   logic [ssld_pkg::MS_W-1:0]    init_ff, init_in;
   logic [ssld_pkg::SPL_W-1:0]   spl_ff, spl_in;

   // Detector state.
   logic                         above_ff, above_in;
   logic [ssld_pkg::TIME_W-1:0]  rise_ff, rise_in;
   logic [ssld_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [ssld_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [ssld_pkg::MS_W-1:0]    avg_ff, avg_in;
   logic [ssld_pkg::TIME_W-1:0]  first_ff, first_in;

   // Per-sample working registers.
   logic [ssld_pkg::ACCEL_W-1:0] accel_ff, accel_in;
   logic [ssld_pkg::TIME_W-1:0]  time_ff, time_in;
   logic                         counted_ff, counted_in;
   logic [ssld_pkg::APROD_W-1:0] aprod_ff, aprod_in;
   logic [ssld_pkg::PCT_W-1:0]   pct_ff, pct_in;
   logic [ssld_pkg::WPROD_W-1:0] wprod_ff, wprod_in;
   logic [ssld_pkg::WIN_W-1:0]   win_ff, win_in;
   ssld_pkg::rsp_type            rsp_ff, rsp_in;

   logic                            rise_ev, fall_ev, qualify, need_avg;
   logic [ssld_pkg::TIME_W-1:0]     dur, gap;
   logic [ssld_pkg::PC_W-2:0]       strokes;
   logic                            pct_needed, close_len, accept_len, sat;
   logic [ssld_pkg::SPL_W-1:0]      spl_diff;
   logic [ssld_pkg::PCT_NUM_W-1:0]  pct_num;
   logic [ssld_pkg::FACT_W-1:0]     fact;
   logic [ssld_pkg::SCALE_W-1:0]    scaled;
   logic [ssld_pkg::MS_W-1:0]       avg_capped;
   logic                            div_start;
   logic [ssld_pkg::DIVD_W-1:0]     div_dividend, quot;
   logic [ssld_pkg::DVSR_W-1:0]     div_divisor;
   logic [ssld_pkg::STEP_W-1:0]     div_steps;
   logic                            div_busy;
   ssld_pkg::rsp_type               rsp_next;

   // Peak detection on the latched sample.
   assign rise_ev  = (accel_ff > thr_ff) && !above_ff;
   assign fall_ev  = (accel_ff < thr_ff) && above_ff;
   assign dur      = time_ff - rise_ff;
   assign gap      = time_ff - last_ff;
   assign qualify  = fall_ev && (dur > ssld_pkg::TIME_W'(min_ff));
   assign need_avg = qualify && (pc_ff > ssld_pkg::PC_W'(ssld_pkg::AVG_MIN_COUNT));

   // Window percentage and length decision.
   assign strokes    = pc_ff[ssld_pkg::PC_W-1:1];
   assign pct_needed = ssld_pkg::CMP_W'(strokes) < ssld_pkg::CMP_W'(spl_ff);
   assign spl_diff   = spl_ff - ssld_pkg::SPL_W'(strokes);
   assign pct_num    = ssld_pkg::PCT_NUM_W'(ssld_pkg::PCT_FULL)
                       * ssld_pkg::PCT_NUM_W'(spl_diff);
   assign fact       = ssld_pkg::FACT_W'(ssld_pkg::WIN_BASE)
                       + ssld_pkg::FACT_W'({pct_ff, 1'b0});
   assign scaled     = ssld_pkg::SCALE_W'(wprod_ff) * ssld_pkg::SCALE_W'(ssld_pkg::RECIP_K);
   assign close_len  = (pc_ff != '0)
                       && (ssld_pkg::WCMP_W'(gap) > ssld_pkg::WCMP_W'(win_ff));
   assign accept_len = ssld_pkg::CMP_W'(strokes) >= ssld_pkg::CMP_W'(spl_ff >> 2);
   assign sat        = ssld_pkg::CMP_W'(strokes) > ssld_pkg::CMP_W'(ssld_pkg::STROKES_MAX);

   assign avg_capped = (quot > ssld_pkg::DIVD_W'(max_ff))
                       ? max_ff : quot[ssld_pkg::MS_W-1:0];

   // Divider operand selection.
   assign div_start    = cmd.avg_div || cmd.pct_div;
   assign div_dividend = cmd.avg_div
      ? (ssld_pkg::DIVD_W'(aprod_ff) + ssld_pkg::DIVD_W'(gap))
      : {pct_num, {(ssld_pkg::DIVD_W - ssld_pkg::PCT_NUM_W){1'b0}}};
   assign div_divisor  = cmd.avg_div ? ssld_pkg::DVSR_W'(pc_ff)
                                     : ssld_pkg::DVSR_W'(spl_ff);
   assign div_steps    = cmd.avg_div ? ssld_pkg::STEP_W'(ssld_pkg::DIVD_W)
                                     : ssld_pkg::STEP_W'(ssld_pkg::PCT_NUM_W);

   ssld_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_comb begin
      rsp_next.length_done     = close_len && accept_len;
      rsp_next.peak_counted    = counted_ff;
      rsp_next.length_start_ms = (close_len && accept_len) ? first_ff : '0;
      rsp_next.length_end_ms   = (close_len && accept_len) ? time_ff : '0;
      if (close_len && !accept_len) begin
         rsp_next.length_strokes = '0;
      end else if (sat) begin
         rsp_next.length_strokes = ssld_pkg::STROKES_MAX;
      end else begin
         rsp_next.length_strokes = ssld_pkg::STROKES_W'(strokes);
      end
   end

   always_comb begin
      thr_in     = thr_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      init_in    = init_ff;
      spl_in     = spl_ff;
      above_in   = above_ff;
      rise_in    = rise_ff;
      last_in    = last_ff;
      pc_in      = pc_ff;
      avg_in     = avg_ff;
      first_in   = first_ff;
      accel_in   = accel_ff;
      time_in    = time_ff;
      counted_in = counted_ff;
      aprod_in   = aprod_ff;
      pct_in     = pct_ff;
      wprod_in   = wprod_ff;
      win_in     = win_ff;
      rsp_in     = rsp_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            ssld_pkg::REG_PEAK_THRESHOLD: begin
               thr_in = csr_wdata[ssld_pkg::ACCEL_W-1:0];
            end
            ssld_pkg::REG_MIN_PEAK_MS: begin
               min_in = csr_wdata[ssld_pkg::MS_W-1:0];
            end
            ssld_pkg::REG_MAX_AVG_GAP_MS: begin
               max_in = csr_wdata[ssld_pkg::MS_W-1:0];
            end
            ssld_pkg::REG_INITIAL_AVG_GAP_MS: begin
               init_in = csr_wdata[ssld_pkg::MS_W-1:0];
               avg_in  = csr_wdata[ssld_pkg::MS_W-1:0];
            end
            ssld_pkg::REG_STROKES_PER_LENGTH: begin
               spl_in = csr_wdata[ssld_pkg::SPL_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         accel_in = req_data.accel;
         time_in  = req_data.time_ms;
      end

      if (cmd.peak) begin
         counted_in = qualify;
         if (rise_ev) begin
            above_in = 1'b1;
            rise_in  = time_ff;
         end
         if (fall_ev) begin
            above_in = 1'b0;
         end
      end

      if (cmd.avg_mul) begin
         aprod_in = ssld_pkg::APROD_W'(avg_ff) * ssld_pkg::APROD_W'(pc_ff - 1'b1);
      end

      if (cmd.avg_commit) begin
         avg_in = avg_capped;
      end

      if (cmd.peak_commit) begin
         last_in = time_ff;
         if (pc_ff != '1) begin
            pc_in = pc_ff + 1'b1;
         end
         if (pc_ff == '0) begin
            first_in = time_ff;
         end
      end

      if (cmd.pct_zero) begin
         pct_in = '0;
      end
      if (cmd.pct_load) begin
         pct_in = quot[ssld_pkg::PCT_W-1:0];
      end

      if (cmd.win_mul) begin
         wprod_in = ssld_pkg::WPROD_W'(avg_ff) * ssld_pkg::WPROD_W'(fact);
      end
      if (cmd.win_scale) begin
         win_in = scaled[ssld_pkg::SCALE_W-1:ssld_pkg::RECIP_SHIFT];
      end

      if (cmd.finish) begin
         rsp_in = rsp_next;
         if (close_len) begin
            above_in = 1'b0;
            pc_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      accel_ff   <= accel_in;
      time_ff    <= time_in;
      counted_ff <= counted_in;
      aprod_ff   <= aprod_in;
      pct_ff     <= pct_in;
      wprod_ff   <= wprod_in;
      win_ff     <= win_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         thr_ff   <= ssld_pkg::RST_PEAK_THRESHOLD;
         min_ff   <= ssld_pkg::RST_MIN_PEAK_MS;
         max_ff   <= ssld_pkg::RST_MAX_AVG_GAP_MS;
         init_ff  <= ssld_pkg::RST_INITIAL_AVG_GAP_MS;
         spl_ff   <= ssld_pkg::RST_STROKES_PER_LENGTH;
         above_ff <= 1'b0;
         rise_ff  <= '0;
         last_ff  <= '0;
         pc_ff    <= '0;
         avg_ff   <= ssld_pkg::RST_INITIAL_AVG_GAP_MS;
         first_ff <= '0;
      end else begin
         thr_ff   <= thr_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         init_ff  <= init_in;
         spl_ff   <= spl_in;
         above_ff <= above_in;
         rise_ff  <= rise_in;
         last_ff  <= last_in;
         pc_ff    <= pc_in;
         avg_ff   <= avg_in;
         first_ff <= first_in;
      end
   end

   assign status.qualify    = qualify;
   assign status.need_avg   = need_avg;
   assign status.pct_needed = pct_needed;
   assign status.div_busy   = div_busy;
   assign rsp_data          = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/ssld_ctrl.sv
// Controller state machine: sequences one sample through the datapath and
// owns both handshakes. Depends on ssld_pkg.
`default_nettype none

module ssld_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire ssld_pkg::dp_status_type  status,
   output ssld_pkg::ctrl_cmd_type        cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PEAK  = 4'd1;
   localparam logic [3:0] ST_AMUL  = 4'd2;
   localparam logic [3:0] ST_ADIV  = 4'd3;
   localparam logic [3:0] ST_AWAIT = 4'd4;
   localparam logic [3:0] ST_PCT   = 4'd5;
   localparam logic [3:0] ST_PWAIT = 4'd6;
   localparam logic [3:0] ST_WMUL  = 4'd7;
   localparam logic [3:0] ST_WSCL  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            cmd.peak = 1'b1;
            if (status.need_avg) begin
               state_in = ST_AMUL;
            end else begin
               cmd.peak_commit = status.qualify;
               state_in        = ST_PCT;
            end
         end
         ST_AMUL: begin
            cmd.avg_mul = 1'b1;
            state_in    = ST_ADIV;
         end
         ST_ADIV: begin
            cmd.avg_div = 1'b1;
            state_in    = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (!status.div_busy) begin
               cmd.avg_commit  = 1'b1;
               cmd.peak_commit = 1'b1;
               state_in        = ST_PCT;
            end
         end
         ST_PCT: begin
            if (status.pct_needed) begin
               cmd.pct_div = 1'b1;
               state_in    = ST_PWAIT;
            end else begin
               cmd.pct_zero = 1'b1;
               state_in     = ST_WMUL;
            end
         end
         ST_PWAIT: begin
            if (!status.div_busy) begin
               cmd.pct_load = 1'b1;
               state_in     = ST_WMUL;
            end
         end
         ST_WMUL: begin
            cmd.win_mul = 1'b1;
            state_in    = ST_WSCL;
         end
         ST_WSCL: begin
            cmd.win_scale = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/swim_stroke_length_detector_unit.sv
// Swim stroke and length detector, top level. Each accepted transaction
// carries one acceleration sample and its millisecond timestamp and yields
// exactly one result transaction. A sample that needs no division passes
// through the controller states PEAK, PCT, WMUL, WSCL and DONE, and its
// result is registered on leaving DONE. A sample that ends a qualifying peak
// from the eighth peak on also passes through AMUL, ADIV and AWAIT for the
// running-average division. A sample whose stroke count is still below
// strokes_per_length also waits in PWAIT for the window percentage division.
// Both divisions share the single radix-2 divider in the datapath, which
// retires one quotient bit per cycle. A new sample is accepted once the
// previous one has been placed in the result register, even while that
// result is still stalled. Configuration registers may be written at any time
// the block holds no transaction in progress; writing initial_avg_gap_ms also
// reloads the learned average gap. There is no clearing pass after reset.
`default_nettype none

module swim_stroke_length_detector_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Sample channel.
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ssld_pkg::req_type                req_data,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ssld_pkg::rsp_type                     rsp_data,
   // Configuration write port.
   input  wire logic                             csr_wr_en,
   input  wire logic [ssld_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssld_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // The controller only sequences; every value lives in the datapath.
   ssld_pkg::ctrl_cmd_type  cmd;
   ssld_pkg::dp_status_type status;

   ssld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the detector state, the shared
   // divider and the result register that decouples the two channels.
   ssld_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hdl/ssld_checker.sv
// Port-level checker for the swim stroke and length detector, bound to the
// top level. Depends on ssld_pkg.
`default_nettype none

module ssld_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire ssld_pkg::rsp_type  rsp_data
);

   // Transactions accepted at the input and not yet delivered.
   logic [1:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Every result belongs to an accepted sample, and at most two are in flight.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a sample");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many samples in flight");

   // A sample that counts a peak resets the gap, so it can never close a length.
   a_done_not_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.length_done && rsp_data.peak_counted))
      else $error("length closed on a counted peak");

   // Times are reported only for an accepted length.
   a_times_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.length_done |->
         rsp_data.length_start_ms == '0 && rsp_data.length_end_ms == '0)
      else $error("length times without a closed length");

endmodule

bind swim_stroke_length_detector_unit ssld_checker u_ssld_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
